// ===== hdl/smeu_pkg.sv =====
package smeu_pkg;

  localparam int unsigned SMEU_STACK_DEPTH = 64;
  localparam int unsigned SMEU_WORD_WIDTH  = 32;
  localparam int unsigned OP_W             = 4;
  localparam int unsigned STATUS_W         = 3;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH = 4'd0,
    OP_POP  = 4'd1,
    OP_DUP  = 4'd2,
    OP_SWAP = 4'd3,
    OP_ADD  = 4'd4,
    OP_SUB  = 4'd5,
    OP_MUL  = 4'd6,
    OP_DIV  = 4'd7,
    OP_MOD  = 4'd8,
    OP_JEQ  = 4'd9,
    OP_JNE  = 4'd10,
    OP_JGT  = 4'd11,
    OP_JLT  = 4'd12,
    OP_JMP  = 4'd13,
    OP_RET  = 4'd14
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_UNDER   = 3'd1,
    ST_OVER    = 3'd2,
    ST_DIVZ    = 3'd3,
    ST_RET     = 3'd4,
    ST_STOPPED = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    CM_HOLD,
    CM_ABOVE,
    CM_BELOW
  } cell_mode_e;

  typedef struct packed {
    cell_mode_e top;
    cell_mode_e second;
    cell_mode_e rest;
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    SER_MUL,
    SER_DIV,
    SER_MOD
  } ser_op_e;

endpackage

// ===== hdl/smeu_cell.sv =====
module smeu_cell
  import smeu_pkg::*;
#(
  parameter int unsigned WORD_WIDTH = SMEU_WORD_WIDTH
) (
  input  logic                  clk_i,
  input  cell_mode_e            mode_i,
  input  logic [WORD_WIDTH-1:0] above_i,
  input  logic [WORD_WIDTH-1:0] below_i,
  output logic [WORD_WIDTH-1:0] data_o
);

  logic [WORD_WIDTH-1:0] data_q;

  always_ff @(posedge clk_i) begin
    unique case (mode_i)
      CM_ABOVE: data_q <= above_i;
      CM_BELOW: data_q <= below_i;
      default:  data_q <= data_q;
    endcase
  end

  assign data_o = data_q;

endmodule

// ===== hdl/smeu_serial.sv =====
module smeu_serial
  import smeu_pkg::*;
#(
  parameter int unsigned WORD_WIDTH = SMEU_WORD_WIDTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  ser_op_e               op_i,
  input  logic [WORD_WIDTH-1:0] a_i,
  input  logic [WORD_WIDTH-1:0] b_i,
  output logic                  done_o,
  output logic [WORD_WIDTH-1:0] result_o
);

  localparam int unsigned CNT_W = $clog2(WORD_WIDTH + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_FIX
  } state_e;

  state_e                state_q;
  ser_op_e               op_q;
  logic [CNT_W-1:0]      cnt_q;
  logic [WORD_WIDTH-1:0] acc_q;
  logic [WORD_WIDTH-1:0] x_q;
  logic [WORD_WIDTH-1:0] y_q;
  logic                  neg_q;
  logic                  done_q;
  logic [WORD_WIDTH-1:0] result_q;

  logic                  a_neg;
  logic                  b_neg;
  logic [WORD_WIDTH-1:0] a_mag;
  logic [WORD_WIDTH-1:0] b_mag;
  logic [WORD_WIDTH:0]   shifted;
  logic [WORD_WIDTH:0]   diff;

  assign a_neg   = a_i[WORD_WIDTH-1];
  assign b_neg   = b_i[WORD_WIDTH-1];
  assign a_mag   = a_neg ? (~a_i + 1'b1) : a_i;
  assign b_mag   = b_neg ? (~b_i + 1'b1) : b_i;
  assign shifted = {acc_q, y_q[WORD_WIDTH-1]};
  assign diff    = shifted - {1'b0, x_q};

  // Multiply is shift-and-add, divide is restoring on magnitudes; both take one bit a cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      op_q     <= SER_MUL;
      cnt_q    <= '0;
      acc_q    <= '0;
      x_q      <= '0;
      y_q      <= '0;
      neg_q    <= 1'b0;
      done_q   <= 1'b0;
      result_q <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          done_q <= 1'b0;
          if (start_i) begin
            op_q  <= op_i;
            cnt_q <= CNT_W'(WORD_WIDTH);
            acc_q <= '0;
            if (op_i == SER_MUL) begin
              x_q   <= b_i;
              y_q   <= a_i;
              neg_q <= 1'b0;
            end else begin
              x_q   <= a_mag;
              y_q   <= b_mag;
              neg_q <= (op_i == SER_DIV) ? (a_neg ^ b_neg) : b_neg;
            end
            state_q <= S_RUN;
          end
        end
        S_RUN: begin
          if (op_q == SER_MUL) begin
            if (y_q[0]) begin
              acc_q <= acc_q + x_q;
            end
            x_q <= x_q << 1;
            y_q <= y_q >> 1;
          end else if (!diff[WORD_WIDTH]) begin
            acc_q <= diff[WORD_WIDTH-1:0];
            y_q   <= {y_q[WORD_WIDTH-2:0], 1'b1};
          end else begin
            acc_q <= shifted[WORD_WIDTH-1:0];
            y_q   <= {y_q[WORD_WIDTH-2:0], 1'b0};
          end
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == CNT_W'(1)) begin
            state_q <= S_FIX;
          end
        end
        S_FIX: begin
          if (op_q == SER_MUL) begin
            result_q <= acc_q;
          end else if (op_q == SER_DIV) begin
            result_q <= neg_q ? (~y_q + 1'b1) : y_q;
          end else begin
            result_q <= neg_q ? (~acc_q + 1'b1) : acc_q;
          end
          done_q  <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign done_o   = done_q;
  assign result_o = result_q;

endmodule

// ===== hdl/stack_machine_execute_unit.sv =====
// Channel  Direction  Ports            Payload
// s_axis   in         tvalid tready    tdata: op, immediate
// m_axis   out        tvalid tready    tdata: branch_taken, top_value, stack_depth, status
//
// After the accepting edge a request passes through S_EXEC and S_FIN; the conditional
// jumps also pass S_POP2, and mul, div and mod wait in S_WAIT for the bit-serial unit.
// m_axis_tvalid is registered in S_FIN, and s_axis_tready is high again once the result
// is registered; the next request is accepted while a result still waits.
// The stack is a row of cells with the top in the first cell; every push or pop shifts it.
// Reset clears the depth and the stopped flag; the cell contents are not cleared.
// A stalled output holds its result, and the block stops before overwriting it.
module stack_machine_execute_unit
  import smeu_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = SMEU_STACK_DEPTH,
  parameter int unsigned WORD_WIDTH  = SMEU_WORD_WIDTH,
  localparam int unsigned DEPTH_W    = $clog2(STACK_DEPTH + 1),
  localparam int unsigned IN_W       = ((OP_W + WORD_WIDTH + 7) / 8) * 8,
  localparam int unsigned OUT_BITS   = 1 + WORD_WIDTH + DEPTH_W + STATUS_W,
  localparam int unsigned OUT_W      = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // op, immediate
  input  logic [IN_W-1:0]  s_axis_tdata,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // branch_taken, top_value, stack_depth, status
  output logic [OUT_W-1:0] m_axis_tdata
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_WAIT,
    S_POP2,
    S_FIN
  } state_e;

  state_e                state_q, state_d;
  logic [OP_W-1:0]       op_q, op_d;
  logic [WORD_WIDTH-1:0] imm_q, imm_d;
  logic [DEPTH_W-1:0]    count_q, count_d;
  logic                  stopped_q, stopped_d;
  status_e               status_q, status_d;
  logic                  taken_q, taken_d;
  logic                  out_valid_q, out_valid_d;
  logic [OUT_W-1:0]      out_data_q, out_data_d;

  cell_ctrl_t            ctrl;
  logic [WORD_WIDTH-1:0] inject;
  logic [WORD_WIDTH-1:0] cell_data [STACK_DEPTH];
  logic [WORD_WIDTH-1:0] a;
  logic [WORD_WIDTH-1:0] b;
  logic [WORD_WIDTH-1:0] top;
  logic                  full;
  logic                  ser_start;
  ser_op_e               ser_op;
  logic                  ser_done;
  logic [WORD_WIDTH-1:0] ser_result;

  assign a    = cell_data[0];
  assign b    = cell_data[1];
  assign full = (count_q == DEPTH_W'(STACK_DEPTH));
  assign top  = (count_q == '0) ? '0 : a;

  for (genvar k = 0; k < STACK_DEPTH; k++) begin : g_cell
    cell_mode_e            mode;
    logic [WORD_WIDTH-1:0] above;
    logic [WORD_WIDTH-1:0] below;

    if (k == 0) begin : g_top
      assign mode  = ctrl.top;
      assign above = inject;
    end else if (k == 1) begin : g_second
      assign mode  = ctrl.second;
      assign above = cell_data[k-1];
    end else begin : g_rest
      assign mode  = ctrl.rest;
      assign above = cell_data[k-1];
    end

    if (k == STACK_DEPTH - 1) begin : g_bottom
      assign below = '0;
    end else begin : g_inner
      assign below = cell_data[k+1];
    end

    smeu_cell #(
      .WORD_WIDTH(WORD_WIDTH)
    ) u_cell (
      .clk_i  (clk_i),
      .mode_i (mode),
      .above_i(above),
      .below_i(below),
      .data_o (cell_data[k])
    );
  end

  smeu_serial #(
    .WORD_WIDTH(WORD_WIDTH)
  ) u_serial (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ser_start),
    .op_i    (ser_op),
    .a_i     (a),
    .b_i     (b),
    .done_o  (ser_done),
    .result_o(ser_result)
  );

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    imm_d       = imm_q;
    count_d     = count_q;
    stopped_d   = stopped_q;
    status_d    = status_q;
    taken_d     = taken_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    ctrl        = '{top: CM_HOLD, second: CM_HOLD, rest: CM_HOLD};
    inject      = a;
    ser_start   = 1'b0;
    ser_op      = SER_MUL;

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          op_d    = s_axis_tdata[OP_W-1:0];
          imm_d   = s_axis_tdata[OP_W +: WORD_WIDTH];
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        status_d = ST_OK;
        taken_d  = 1'b0;
        state_d  = S_FIN;
        if (stopped_q) begin
          status_d = ST_STOPPED;
        end else begin
          unique case (op_e'(op_q)) inside
            OP_PUSH: begin
              if (full) begin
                status_d = ST_OVER;
              end else begin
                ctrl    = '{top: CM_ABOVE, second: CM_ABOVE, rest: CM_ABOVE};
                inject  = imm_q;
                count_d = count_q + 1'b1;
              end
            end
            OP_POP: begin
              if (count_q == '0) begin
                status_d = ST_UNDER;
              end else begin
                ctrl    = '{top: CM_BELOW, second: CM_BELOW, rest: CM_BELOW};
                count_d = count_q - 1'b1;
              end
            end
            OP_DUP: begin
              if (count_q == '0) begin
                status_d = ST_UNDER;
              end else if (full) begin
                status_d = ST_OVER;
              end else begin
                ctrl    = '{top: CM_ABOVE, second: CM_ABOVE, rest: CM_ABOVE};
                count_d = count_q + 1'b1;
              end
            end
            OP_SWAP, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD,
            OP_JEQ, OP_JNE, OP_JGT, OP_JLT: begin
              if (count_q < DEPTH_W'(2)) begin
                status_d = ST_UNDER;
              end else if ((op_e'(op_q) == OP_DIV || op_e'(op_q) == OP_MOD) && a == '0) begin
                status_d = ST_DIVZ;
              end else begin
                unique case (op_e'(op_q)) inside
                  OP_SWAP: begin
                    ctrl = '{top: CM_BELOW, second: CM_ABOVE, rest: CM_HOLD};
                  end
                  OP_ADD, OP_SUB: begin
                    ctrl    = '{top: CM_ABOVE, second: CM_BELOW, rest: CM_BELOW};
                    inject  = (op_e'(op_q) == OP_ADD) ? (b + a) : (b - a);
                    count_d = count_q - 1'b1;
                  end
                  OP_MUL, OP_DIV, OP_MOD: begin
                    ser_start = 1'b1;
                    ser_op    = (op_e'(op_q) == OP_MUL) ? SER_MUL :
                                (op_e'(op_q) == OP_DIV) ? SER_DIV : SER_MOD;
                    state_d   = S_WAIT;
                  end
                  default: begin
                    unique case (op_e'(op_q))
                      OP_JEQ:  taken_d = (a == b);
                      OP_JNE:  taken_d = (a != b);
                      OP_JGT:  taken_d = ($signed(b) > $signed(a));
                      default: taken_d = ($signed(b) < $signed(a));
                    endcase
                    ctrl    = '{top: CM_BELOW, second: CM_BELOW, rest: CM_BELOW};
                    count_d = count_q - DEPTH_W'(2);
                    state_d = S_POP2;
                  end
                endcase
              end
            end
            OP_JMP:  taken_d = 1'b1;
            OP_RET:  status_d = ST_RET;
            default: status_d = ST_OK;
          endcase
        end
        if (status_d != ST_OK && status_d != ST_STOPPED) begin
          stopped_d = 1'b1;
        end
      end
      S_WAIT: begin
        if (ser_done) begin
          ctrl    = '{top: CM_ABOVE, second: CM_BELOW, rest: CM_BELOW};
          inject  = ser_result;
          count_d = count_q - 1'b1;
          state_d = S_FIN;
        end
      end
      S_POP2: begin
        ctrl    = '{top: CM_BELOW, second: CM_BELOW, rest: CM_BELOW};
        state_d = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_data_d  = OUT_W'({status_q, count_q, top, taken_q});
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= '0;
      imm_q       <= '0;
      count_q     <= '0;
      stopped_q   <= 1'b0;
      status_q    <= ST_OK;
      taken_q     <= 1'b0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      imm_q       <= imm_d;
      count_q     <= count_d;
      stopped_q   <= stopped_d;
      status_q    <= status_d;
      taken_q     <= taken_d;
      out_valid_q <= out_valid_d;
      out_data_q  <= out_data_d;
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// ===== hdl/smeu_checker.sv =====
module smeu_checker
  import smeu_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = SMEU_STACK_DEPTH,
  parameter int unsigned WORD_WIDTH  = SMEU_WORD_WIDTH,
  localparam int unsigned DEPTH_W    = $clog2(STACK_DEPTH + 1),
  localparam int unsigned IN_W       = ((OP_W + WORD_WIDTH + 7) / 8) * 8,
  localparam int unsigned OUT_BITS   = 1 + WORD_WIDTH + DEPTH_W + STATUS_W,
  localparam int unsigned OUT_W      = ((OUT_BITS + 7) / 8) * 8
) (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             s_axis_tvalid,
  input logic             s_axis_tready,
  input logic [IN_W-1:0]  s_axis_tdata,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [OUT_W-1:0] m_axis_tdata
);

  logic                  out_fire;
  logic                  in_fire;
  logic                  o_taken;
  logic [WORD_WIDTH-1:0] o_top;
  logic [DEPTH_W-1:0]    o_depth;
  logic [STATUS_W-1:0]   o_status;
  logic                  halted_q;
  logic                  pending_q;

  assign in_fire  = s_axis_tvalid && s_axis_tready && (s_axis_tdata[0] || !s_axis_tdata[0]);
  assign out_fire = m_axis_tvalid && m_axis_tready;
  assign o_taken  = m_axis_tdata[0];
  assign o_top    = m_axis_tdata[1 +: WORD_WIDTH];
  assign o_depth  = m_axis_tdata[1 + WORD_WIDTH +: DEPTH_W];
  assign o_status = m_axis_tdata[1 + WORD_WIDTH + DEPTH_W +: STATUS_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      halted_q  <= 1'b0;
      pending_q <= 1'b0;
    end else begin
      if (out_fire && (o_status == ST_UNDER || o_status == ST_OVER ||
                       o_status == ST_DIVZ || o_status == ST_RET)) begin
        halted_q <= 1'b1;
      end
      if (in_fire) begin
        pending_q <= 1'b1;
      end
    end
  end

  a_halted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire |-> (halted_q == (o_status == ST_STOPPED)))
    else $error("stopped status does not match an earlier error or return");

  a_empty_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && o_depth == '0 |-> o_top == '0)
    else $error("empty stack shows a nonzero top value");

  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire |-> (o_depth <= DEPTH_W'(STACK_DEPTH)) && pending_q)
    else $error("result depth beyond the stack size or result without request");

  a_taken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && o_taken |-> o_status == ST_OK)
    else $error("branch taken together with a failing status");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

endmodule

bind stack_machine_execute_unit smeu_checker #(
  .STACK_DEPTH(STACK_DEPTH),
  .WORD_WIDTH (WORD_WIDTH)
) u_smeu_checker (.*);

// ===== verif/stack_machine_execute_unit_test.sv =====
`timescale 1ns / 100ps

module stack_machine_execute_unit_test
  import smeu_pkg::*;
();

  localparam int unsigned STACK_DEPTH     = SMEU_STACK_DEPTH;
  localparam int unsigned WORD_W          = SMEU_WORD_WIDTH;
  localparam int unsigned DEPTH_W         = $clog2(STACK_DEPTH + 1);
  localparam int unsigned IN_W            = ((OP_W + WORD_W + 7) / 8) * 8;
  localparam int unsigned RES_W           = 1 + WORD_W + DEPTH_W + STATUS_W;
  localparam int unsigned OUT_W           = ((RES_W + 7) / 8) * 8;
  localparam int unsigned PHASE_ITEMS     = 450;
  localparam int unsigned HOLD_OFF_CYCLES = 400;
  localparam int unsigned DRAIN_CYCLES    = 64;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [DEPTH_W-1:0]  depth;
    logic [WORD_W-1:0]   top;
    logic                taken;
  } result_t;

  class stack_tracker;
    logic [WORD_W-1:0] cells [STACK_DEPTH];
    int unsigned       count;
    bit                halted;
    result_t           pending_results [$];
    int unsigned       mismatches;

    function void note_request(logic [OP_W-1:0] op, logic [WORD_W-1:0] imm);
      result_t           exp;
      logic [WORD_W-1:0] a, b, r, ma, mb;
      logic [STATUS_W-1:0] st;
      exp = '0;
      st  = ST_OK;
      if (halted) begin
        st = ST_STOPPED;
      end else if (op == OP_PUSH) begin
        if (count >= STACK_DEPTH) st = ST_OVER;
        else begin
          cells[count] = imm;
          count++;
        end
      end else if (op == OP_POP) begin
        if (count < 1) st = ST_UNDER;
        else count--;
      end else if (op == OP_DUP) begin
        if (count < 1) st = ST_UNDER;
        else if (count >= STACK_DEPTH) st = ST_OVER;
        else begin
          cells[count] = cells[count-1];
          count++;
        end
      end else if (op >= OP_SWAP && op <= OP_JLT) begin
        if (count < 2) begin
          st = ST_UNDER;
        end else begin
          a = cells[count-1];
          b = cells[count-2];
          if ((op == OP_DIV || op == OP_MOD) && a == 0) begin
            st = ST_DIVZ;
          end else if (op == OP_SWAP) begin
            cells[count-1] = b;
            cells[count-2] = a;
          end else if (op >= OP_JEQ) begin
            case (op)
              OP_JEQ:  exp.taken = (a == b);
              OP_JNE:  exp.taken = (a != b);
              OP_JGT:  exp.taken = ($signed(b) > $signed(a));
              default: exp.taken = ($signed(b) < $signed(a));
            endcase
            count -= 2;
          end else begin
            // Division works on magnitudes so the most negative value
            // divided by minus one wraps instead of overflowing.
            ma = a[WORD_W-1] ? -a : a;
            mb = b[WORD_W-1] ? -b : b;
            case (op)
              OP_ADD: r = b + a;
              OP_SUB: r = b - a;
              OP_MUL: r = b * a;
              OP_DIV: begin
                r = mb / ma;
                if (a[WORD_W-1] != b[WORD_W-1]) r = -r;
              end
              default: begin
                r = mb % ma;
                if (b[WORD_W-1]) r = -r;
              end
            endcase
            count--;
            cells[count-1] = r;
          end
        end
      end else if (op == OP_JMP) begin
        exp.taken = 1'b1;
      end else if (op == OP_RET) begin
        st = ST_RET;
      end
      if (st != ST_OK && st != ST_STOPPED) halted = 1'b1;
      exp.status = st;
      exp.depth  = count[DEPTH_W-1:0];
      exp.top    = (count != 0) ? cells[count-1] : '0;
      pending_results = {pending_results, exp};
    endfunction

    function void check_result(result_t got);
      result_t exp;
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding: %h", got);
        mismatches++;
        return;
      end
      exp = pending_results.pop_front();
      if (got.taken !== exp.taken) begin
        $error("branch_taken: expected %0d, actual %0d", exp.taken, got.taken);
        mismatches++;
      end
      if (got.top !== exp.top) begin
        $error("top_value: expected %0d, actual %0d", $signed(exp.top), $signed(got.top));
        mismatches++;
      end
      if (got.depth !== exp.depth) begin
        $error("stack_depth: expected %0d, actual %0d", exp.depth, got.depth);
        mismatches++;
      end
      if (got.status !== exp.status) begin
        $error("status: expected %0d, actual %0d", exp.status, got.status);
        mismatches++;
      end
    endfunction
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             s_axis_tvalid;
  logic             s_axis_tready;
  // op, immediate
  logic [IN_W-1:0]  s_axis_tdata;
  logic             m_axis_tvalid;
  logic             m_axis_tready;
  // branch_taken, top_value, stack_depth, status
  logic [OUT_W-1:0] m_axis_tdata;

  stack_tracker tracker = new();
  int unsigned  send_idle_pct;
  int unsigned  recv_stall_pct;
  bit           hold_off_req;
  bit           rising;

  stack_machine_execute_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  function automatic logic [WORD_W-1:0] random_word();
    logic [WORD_W-1:0] w;
    case ($urandom_range(9))
      0, 1: w = $urandom_range(16) - 8;
      2: begin
        case ($urandom_range(4))
          0:       w = {1'b1, {(WORD_W-1){1'b0}}};
          1:       w = {1'b0, {(WORD_W-1){1'b1}}};
          2:       w = '0;
          3:       w = '1;
          default: w = 1;
        endcase
      end
      default: w = $urandom();
    endcase
    return w;
  endfunction

  task automatic send_request(input logic [OP_W-1:0] op, input logic [WORD_W-1:0] imm);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(IN_W - OP_W - WORD_W){1'b0}}, imm, op};
    do @(posedge clk_i); while (!s_axis_tready);
    tracker.note_request(op, imm);
  endtask

  // Keeps the stack legal so the machine never stops during the random part;
  // the depth drifts between empty and full.
  task automatic run_random(input int unsigned n);
    logic [OP_W-1:0] op;
    int unsigned     d;
    bit              ok;
    repeat (n) begin
      d = tracker.count;
      if (d >= STACK_DEPTH) rising = 1'b0;
      else if (d <= 1) rising = 1'b1;
      else if ($urandom_range(99) < 3) rising = !rising;
      do begin
        if ($urandom_range(99) < 60)
          op = rising ? (($urandom_range(3) != 0) ? OP_PUSH : OP_DUP) : OP_POP;
        else
          op = OP_W'($urandom_range(15));
        case (op)
          OP_PUSH: ok = (d < STACK_DEPTH);
          OP_POP:  ok = (d >= 1);
          OP_DUP:  ok = (d >= 1) && (d < STACK_DEPTH);
          OP_DIV, OP_MOD: ok = (d >= 2) && (tracker.cells[d-1] != 0);
          OP_SWAP, OP_ADD, OP_SUB, OP_MUL, OP_JEQ, OP_JNE, OP_JGT, OP_JLT: ok = (d >= 2);
          OP_RET:  ok = 1'b0;
          default: ok = 1'b1;
        endcase
      end while (!ok);
      send_request(op, random_word());
    end
  endtask

  initial begin
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
      end
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      tracker.check_result(m_axis_tdata[RES_W-1:0]);
    end
  end

  initial begin
    #4000000;
    $display("stack_machine_execute_unit_test NOT OK");
    $finish;
  end

  initial begin
    int unsigned ending;
    logic [OP_W-1:0] last_op;
    rst_ni         <= 1'b0;
    s_axis_tvalid  <= 1'b0;
    s_axis_tdata   <= '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_request(OP_PUSH, 32'h7fff_ffff);
    send_request(OP_PUSH, 32'd1);
    send_request(OP_ADD, random_word());
    send_request(OP_PUSH, 32'hffff_ffff);
    send_request(OP_DIV, random_word());
    send_request(OP_DUP, random_word());
    send_request(OP_PUSH, 32'hffff_ffff);
    send_request(OP_MOD, random_word());
    send_request(OP_JEQ, random_word());
    send_request(OP_PUSH, -32'sd7);
    send_request(OP_PUSH, 32'd2);
    send_request(OP_DIV, random_word());
    send_request(OP_PUSH, 32'd7);
    send_request(OP_PUSH, -32'sd2);
    send_request(OP_MOD, random_word());
    send_request(OP_SWAP, random_word());
    send_request(OP_SUB, random_word());
    send_request(OP_PUSH, 32'h8000_0000);
    send_request(OP_MUL, random_word());
    send_request(OP_DUP, random_word());
    send_request(OP_JNE, random_word());
    send_request(OP_PUSH, 32'd3);
    send_request(OP_PUSH, 32'd2);
    send_request(OP_JGT, random_word());
    send_request(OP_PUSH, 32'd1);
    send_request(OP_PUSH, 32'd2);
    send_request(OP_JLT, random_word());
    send_request(OP_JMP, random_word());
    send_request('1, 32'hffff_ffff);
    send_request(OP_PUSH, 32'd0);
    send_request(OP_POP, random_word());

    run_random(100);
    hold_off_req = 1'b1;
    run_random(PHASE_ITEMS - 100);
    send_idle_pct = 76;
    run_random(PHASE_ITEMS);
    send_idle_pct  = 0;
    recv_stall_pct = 76;
    run_random(PHASE_ITEMS);
    send_idle_pct  = 23;
    recv_stall_pct = 23;
    run_random(PHASE_ITEMS);

    // The run ends with one stopping event, then requests that must be ignored.
    ending = $urandom_range(3);
    case (ending)
      0: begin
        last_op = OP_W'($urandom_range(1));
        while (tracker.count > last_op) send_request(OP_POP, random_word());
        if (tracker.count == 0) last_op = OP_W'($urandom_range(OP_POP, OP_JLT));
        else last_op = OP_W'($urandom_range(OP_SWAP, OP_JLT));
        send_request(last_op, random_word());
      end
      1: begin
        while (tracker.count < STACK_DEPTH) send_request(OP_PUSH, random_word());
        send_request(($urandom_range(1) != 0) ? OP_PUSH : OP_DUP, random_word());
      end
      2: begin
        while (tracker.count > STACK_DEPTH - 2) send_request(OP_POP, random_word());
        if (tracker.count == 0) send_request(OP_PUSH, random_word());
        send_request(OP_PUSH, '0);
        send_request(($urandom_range(1) != 0) ? OP_DIV : OP_MOD, random_word());
      end
      default: send_request(OP_RET, random_word());
    endcase
    repeat (12) send_request(OP_W'($urandom_range(15)), random_word());
    s_axis_tvalid <= 1'b0;

    while (tracker.pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (tracker.mismatches == 0) begin
      $display("stack_machine_execute_unit_test OK");
    end else begin
      $display("stack_machine_execute_unit_test NOT OK");
    end
    $finish;
  end

endmodule
